// ===== design/gcdlcm_pkg.sv =====
`timescale 1ns / 1ps

package gcdlcm_pkg;

   localparam int OPERAND_WIDTH  = 32;
   localparam int FIELD_WIDTH    = 32;
   localparam int MULTIPLE_WIDTH = 64;
   localparam int PRODUCT_WIDTH  = 2 * OPERAND_WIDTH;
   localparam int COUNT_WIDTH    = $clog2(OPERAND_WIDTH);
   localparam int REQ_DATA_WIDTH = 2 * FIELD_WIDTH;
   localparam int RSP_DATA_WIDTH = FIELD_WIDTH + MULTIPLE_WIDTH;

   localparam logic [COUNT_WIDTH-1:0] COUNT_LAST = COUNT_WIDTH'(OPERAND_WIDTH - 1);

   typedef struct packed {
      logic load;
      logic start_euclid;
      logic start_quotient;
      logic div_step;
      logic euclid_update;
      logic multiply;
      logic result_load;
   } dp_cmd_type;

   typedef struct packed {
      logic zero_both;
      logic small_zero;
      logic div_last;
      logic result_free;
   } dp_status_type;

endpackage

// ===== design/gcd_lcm_unit.sv =====
// Euclid remainder steps and the final quotient step use the shared one-bit-per-cycle
// restoring divider; a pair with both operands zero skips the divider.
// One beat at a time: the next beat is taken once the result is in the output register.
// Reset: synchronous, active high; clears the controller and the output valid flag.
`timescale 1ns / 1ps

module gcd_lcm_unit
   import gcdlcm_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,  // first_operand, second_operand
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,  // divisor_result, multiple_result
   output logic [0:0]                rsp_tuser   // zero_error
);

   dp_cmd_type    cmd;
   dp_status_type status;

   gcdlcm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   gcdlcm_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== design/gcdlcm_ctrl.sv =====
`timescale 1ns / 1ps

module gcdlcm_ctrl
   import gcdlcm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CHECK  = 3'd1;
   localparam logic [2:0] ST_EDIV   = 3'd2;
   localparam logic [2:0] ST_EUPD   = 3'd3;
   localparam logic [2:0] ST_QDIV   = 3'd4;
   localparam logic [2:0] ST_MUL    = 3'd5;
   localparam logic [2:0] ST_FINISH = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            priority if (status.zero_both) begin
               state_in = ST_FINISH;
            end else if (status.small_zero) begin
               cmd.start_quotient = 1'b1;
               state_in           = ST_QDIV;
            end else begin
               cmd.start_euclid = 1'b1;
               state_in         = ST_EDIV;
            end
         end
         ST_EDIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_EUPD;
            end
         end
         ST_EUPD: begin
            cmd.euclid_update = 1'b1;
            state_in          = ST_CHECK;
         end
         ST_QDIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.multiply = 1'b1;
            state_in     = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.result_free) begin
               cmd.result_load = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/gcdlcm_dp.sv =====
`timescale 1ns / 1ps

module gcdlcm_dp
   import gcdlcm_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  dp_cmd_type                cmd,
   output dp_status_type             status,
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,
   output logic [0:0]                rsp_tuser
);

   logic [OPERAND_WIDTH-1:0] op_a;
   logic [OPERAND_WIDTH-1:0] op_b;

   logic [OPERAND_WIDTH-1:0] large_ff;
   logic [OPERAND_WIDTH-1:0] least_ff;
   logic [OPERAND_WIDTH-1:0] big_ff;
   logic [OPERAND_WIDTH-1:0] small_ff;
   logic [OPERAND_WIDTH-1:0] rem_ff;
   logic [OPERAND_WIDTH-1:0] quo_ff;
   logic [OPERAND_WIDTH-1:0] dvs_ff;
   logic [COUNT_WIDTH-1:0]   cnt_ff;
   logic [PRODUCT_WIDTH-1:0] prod_ff;
   logic                     zero_ff;

   logic [FIELD_WIDTH-1:0]    out_divisor_ff;
   logic [MULTIPLE_WIDTH-1:0] out_multiple_ff;
   logic                      out_error_ff;
   logic                      out_valid_ff;
   logic                      out_valid_in;

   logic [OPERAND_WIDTH:0]   shifted;
   logic [OPERAND_WIDTH:0]   diff;
   logic                     fits;

   assign op_a = req_tdata[OPERAND_WIDTH-1:0];
   assign op_b = req_tdata[FIELD_WIDTH +: OPERAND_WIDTH];

   // One restoring division step: shift in the next dividend bit, subtract if it fits.
   assign shifted = {rem_ff, quo_ff[OPERAND_WIDTH-1]};
   assign diff    = shifted - {1'b0, dvs_ff};
   assign fits    = !diff[OPERAND_WIDTH];

   assign status.zero_both   = zero_ff;
   assign status.small_zero  = (small_ff == '0);
   assign status.div_last    = (cnt_ff == COUNT_LAST);
   assign status.result_free = !out_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         zero_ff <= (op_a == '0) && (op_b == '0);
         if (op_a < op_b) begin
            large_ff <= op_b;
            least_ff <= op_a;
            big_ff   <= op_b;
            small_ff <= op_a;
         end else begin
            large_ff <= op_a;
            least_ff <= op_b;
            big_ff   <= op_a;
            small_ff <= op_b;
         end
      end else if (cmd.euclid_update) begin
         big_ff   <= small_ff;
         small_ff <= rem_ff;
      end

      if (cmd.start_euclid) begin
         quo_ff <= big_ff;
         dvs_ff <= small_ff;
         rem_ff <= '0;
         cnt_ff <= '0;
      end else if (cmd.start_quotient) begin
         // Smaller operand over the divisor; the multiple is then the larger times this.
         quo_ff <= least_ff;
         dvs_ff <= big_ff;
         rem_ff <= '0;
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= fits ? diff[OPERAND_WIDTH-1:0] : shifted[OPERAND_WIDTH-1:0];
         quo_ff <= {quo_ff[OPERAND_WIDTH-2:0], fits};
         cnt_ff <= cnt_ff + COUNT_WIDTH'(1);
      end

      if (cmd.multiply) begin
         prod_ff <= PRODUCT_WIDTH'(large_ff) * PRODUCT_WIDTH'(quo_ff);
      end

      if (cmd.result_load) begin
         if (zero_ff) begin
            out_divisor_ff  <= '0;
            out_multiple_ff <= '0;
            out_error_ff    <= 1'b1;
         end else begin
            out_divisor_ff  <= FIELD_WIDTH'(big_ff);
            out_multiple_ff <= MULTIPLE_WIDTH'(prod_ff);
            out_error_ff    <= 1'b0;
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      priority if (cmd.result_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = {out_multiple_ff, out_divisor_ff};
   assign rsp_tuser[0] = out_error_ff;

endmodule

// ===== design/gcdlcm_chk.sv =====
`timescale 1ns / 1ps

module gcdlcm_chk
   import gcdlcm_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [RSP_DATA_WIDTH-1:0] rsp_tdata,
   input logic [0:0]                rsp_tuser
);

   // A stalled result beat holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result beat changed");

   // Both results are zero when the error flag is raised.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("error beat carries nonzero results");

   // Without an error the divisor is never zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[FIELD_WIDTH-1:0] != '0)
      else $error("zero divisor without error");

   // The unit takes no second beat in the cycle after accepting one.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready right after an accepted beat");

endmodule

bind gcd_lcm_unit gcdlcm_chk u_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== tb/sv/gcd_lcm_unit_tb.sv =====
`timescale 1ns / 1ps

module gcd_lcm_unit_tb;
   import gcdlcm_pkg::*;

   localparam int CLOCK_HIGH   = 2;
   localparam int CLOCK_LOW    = 2;
   localparam int RESET_CYCLES = 2;
   localparam int RANDOM_PAIRS = 1000;
   localparam int MAX_IDLE     = 18;
   localparam int DRAIN_CYCLES = 1700;
   localparam int CYCLE_LIMIT  = 10_000_000;
   localparam int DIRECTED_PAIRS = 20;

   localparam logic [FIELD_WIDTH-1:0] DIRECTED_FIRST [DIRECTED_PAIRS] = '{
      32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 32'h0000_0000, 32'hFFFF_FFFF,
      32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF,
      32'hFFFF_FFFE, 32'h8000_0000, 32'hB119_24E1, 32'h6D73_E55F, 32'h0000_000C,
      32'h0000_0012, 32'hFFFF_FFFB, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0001_0000
   };
   localparam logic [FIELD_WIDTH-1:0] DIRECTED_SECOND [DIRECTED_PAIRS] = '{
      32'h0000_0000, 32'h0000_0001, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000,
      32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
      32'hFFFF_FFFF, 32'h4000_0000, 32'h6D73_E55F, 32'hB119_24E1, 32'h0000_0012,
      32'h0000_000C, 32'hFFFF_FFEF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF
   };

   typedef struct {
      logic [FIELD_WIDTH-1:0]    divisor;
      logic [MULTIPLE_WIDTH-1:0] multiple;
      logic                      zero_error;
   } gcd_lcm_type;

   class gcd_lcm_scoreboard;
      gcd_lcm_type pending_results[$];
      int          mismatches;
      int          results_checked;
      int          zero_pairs;

      function new();
         mismatches      = 0;
         results_checked = 0;
         zero_pairs      = 0;
      endfunction

      function void note_operands(logic [FIELD_WIDTH-1:0] first, logic [FIELD_WIDTH-1:0] second);
         logic [63:0] mask;
         logic [63:0] larger;
         logic [63:0] smaller;
         logic [63:0] remainder;
         logic [63:0] product;
         gcd_lcm_type want;
         mask    = (64'd1 << OPERAND_WIDTH) - 64'd1;
         larger  = {32'd0, first} & mask;
         smaller = {32'd0, second} & mask;
         if (larger == 64'd0 && smaller == 64'd0) begin
            want.divisor    = '0;
            want.multiple   = '0;
            want.zero_error = 1'b1;
            zero_pairs++;
         end else begin
            if (larger < smaller) begin
               remainder = larger;
               larger    = smaller;
               smaller   = remainder;
            end
            product = larger * smaller;
            while (smaller != 64'd0) begin
               remainder = larger % smaller;
               larger    = smaller;
               smaller   = remainder;
            end
            want.divisor    = larger[FIELD_WIDTH-1:0];
            want.multiple   = product / larger;
            want.zero_error = 1'b0;
         end
         pending_results.push_back(want);
      endfunction

      function void check_result(logic [RSP_DATA_WIDTH-1:0] data, logic zero_flag);
         gcd_lcm_type               want;
         logic [FIELD_WIDTH-1:0]    got_divisor;
         logic [MULTIPLE_WIDTH-1:0] got_multiple;
         got_divisor  = data[FIELD_WIDTH-1:0];
         got_multiple = data[FIELD_WIDTH +: MULTIPLE_WIDTH];
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result beat, divisor %h multiple %h zero_error %b",
                     $time, got_divisor, got_multiple, zero_flag);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            if (got_divisor !== want.divisor) begin
               $display("%0t: divisor_result expected %h actual %h",
                        $time, want.divisor, got_divisor);
               mismatches++;
            end
            if (got_multiple !== want.multiple) begin
               $display("%0t: multiple_result expected %h actual %h",
                        $time, want.multiple, got_multiple);
               mismatches++;
            end
            if (zero_flag !== want.zero_error) begin
               $display("%0t: zero_error expected %b actual %b",
                        $time, want.zero_error, zero_flag);
               mismatches++;
            end
         end
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic [0:0]                rsp_tuser;

   gcd_lcm_scoreboard board;
   bit                sender_quiet;
   bit                receiver_quiet;
   int                pairs_sent;
   longint            cycle_count;

   gcd_lcm_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial clock = 1'b0;

   always begin
      #CLOCK_LOW clock = 1'b1;
      #CLOCK_HIGH clock = 1'b0;
   end

   task automatic send_operands(input logic [FIELD_WIDTH-1:0] first,
                                input logic [FIELD_WIDTH-1:0] second);
      int gap;
      gap = sender_quiet ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {second, first};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_operands(first, second);
      pairs_sent++;
   endtask

   function automatic logic [FIELD_WIDTH-1:0] random_operand();
      logic [FIELD_WIDTH-1:0] value;
      int                     length;
      value  = $urandom;
      length = $urandom_range(1, FIELD_WIDTH);
      case ($urandom_range(0, 9))
         0: begin
            value = '0;
         end
         1, 2: begin
         end
         default: begin
            if (length < FIELD_WIDTH) value = value & ((32'd1 << length) - 32'd1);
         end
      endcase
      return value;
   endfunction

   task automatic send_random_pair();
      logic [FIELD_WIDTH-1:0] first;
      logic [FIELD_WIDTH-1:0] second;
      logic [FIELD_WIDTH-1:0] factor;
      case ($urandom_range(0, 9))
         0, 1: begin
            factor = $urandom_range(1, 65535);
            first  = factor * $urandom_range(0, 65535);
            second = factor * $urandom_range(0, 65535);
         end
         2: begin
            first  = random_operand();
            second = first;
         end
         3: begin
            first  = random_operand() & 32'h00FF_FFFF;
            second = first * $urandom_range(1, 255);
         end
         default: begin
            first  = random_operand();
            second = random_operand();
         end
      endcase
      send_operands(first, second);
   endtask

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Run stopped at the cycle limit with %0d results outstanding.",
               board.pending_results.size());
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      int stall;
      int beats;
      rsp_tready = 1'b0;
      beats      = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = receiver_quiet ? 0 : $urandom_range(0, MAX_IDLE);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         board.check_result(rsp_tdata, rsp_tuser[0]);
         beats++;
         if (beats % 40 == 0) receiver_quiet = ($urandom_range(0, 3) == 0);
      end
   end

   initial begin
      board          = new();
      sender_quiet   = 1'b0;
      receiver_quiet = 1'b0;
      pairs_sent     = 0;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_PAIRS; i++) begin
         send_operands(DIRECTED_FIRST[i], DIRECTED_SECOND[i]);
      end

      for (int i = 0; i < RANDOM_PAIRS; i++) begin
         if (i % 50 == 0) sender_quiet = ($urandom_range(0, 3) == 0);
         if (i == RANDOM_PAIRS / 2) begin
            req_tvalid <= 1'b0;
            while (board.pending_results.size() != 0) @(posedge clock);
         end
         send_random_pair();
      end
      req_tvalid <= 1'b0;

      while (board.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d operand pairs (%0d directed, %0d random), %0d with both operands zero.",
               pairs_sent, DIRECTED_PAIRS, pairs_sent - DIRECTED_PAIRS, board.zero_pairs);
      $display("Checked %0d result beats, %0d mismatches.",
               board.results_checked, board.mismatches);
      if (board.mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
